### design/rrtm_pkg.sv
// shared types and constants of the round-robin thread manager
package rrtm_pkg;

  localparam int THREAD_SLOTS_DEF = 16;

  localparam int OP_W     = 2;
  localparam int ADDR_W   = 32;
  localparam int STATUS_W = 2;
  localparam int TID_W    = 4;
  localparam int COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_YIELD  = 2'd1,
    OP_EXIT   = 2'd2,
    OP_REAP   = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_FREE = 2'd1,
    STAT_NO_RUN  = 2'd2
  } status_t;

endpackage

### design/rrtm_in_if.sv
// command channel of the thread manager
interface rrtm_in_if;
  logic                        valid;
  logic                        ready;
  logic [rrtm_pkg::OP_W-1:0]   op;
  logic [rrtm_pkg::ADDR_W-1:0] entry_addr;

  modport source (output valid, op, entry_addr, input ready);
  modport sink   (input valid, op, entry_addr, output ready);
endinterface

### design/rrtm_out_if.sv
// result channel of the thread manager
interface rrtm_out_if;
  logic                          valid;
  logic                          ready;
  logic [rrtm_pkg::STATUS_W-1:0] status;
  logic [rrtm_pkg::TID_W-1:0]    thread_id;
  logic                          switched;
  logic [rrtm_pkg::ADDR_W-1:0]   resume_addr;
  logic [rrtm_pkg::COUNT_W-1:0]  run_count;
  logic [rrtm_pkg::COUNT_W-1:0]  reaped_count;

  modport source (output valid, status, thread_id, switched, resume_addr, run_count,
                  reaped_count, input ready);
  modport sink   (input valid, status, thread_id, switched, resume_addr, run_count,
                  reaped_count, output ready);
endinterface

### design/round_robin_thread_manager_top.sv
// round-robin thread slot manager: slot table, run queue and result register
//
// usage:
//   in_ch  carries one command beat (op, entry_addr); it is taken when valid and
//          ready are both high. ready is high whenever the sequencer is idle.
//   out_ch returns exactly one result beat per command, in command order.
//   create, exit and reap go from acceptance straight to the result step;
//   yield first does a run queue read, then an entry table read, both through
//   registered memory ports; a yield that finds no runnable thread skips both.
//   one command is worked on at a time; the next command is taken as soon as
//   the previous result sits in the output register, even if it is not taken.
//   if the receiver stalls with a result still held, the finished command waits
//   in its last step and ready stays low until the output register frees up.
//   reset (rst_n low, synchronous) frees every slot, empties the run queue,
//   clears the dead set and drops the current thread. no clearing pass is run:
//   the entry table and queue memory are only read where they were written.
//   dead threads are kept as a bitmap with a count, reap clears it in one step.
module round_robin_thread_manager_top #(
  parameter int THREAD_SLOTS = rrtm_pkg::THREAD_SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  rrtm_in_if.sink     in_ch,
  rrtm_out_if.source  out_ch
);

  localparam int IDW  = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
  localparam int CNTW = $clog2(THREAD_SLOTS + 1);
  localparam int TIDW = rrtm_pkg::TID_W;
  localparam int CW   = rrtm_pkg::COUNT_W;
  localparam int AW   = rrtm_pkg::ADDR_W;
  localparam logic [IDW-1:0] LAST_ID = IDW'(THREAD_SLOTS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIFO,
    S_ENTRY,
    S_DONE
  } state_t;

  state_t state_r;

  // slot bookkeeping
  logic [THREAD_SLOTS-1:0] free_r;
  logic [THREAD_SLOTS-1:0] dead_r;
  logic [CNTW-1:0]         dead_cnt_r;

  // run queue pointers
  logic [IDW-1:0]  head_r;
  logic [IDW-1:0]  tail_r;
  logic [CNTW-1:0] count_r;
  logic            fwd_r;

  // current thread
  logic           cur_valid_r;
  logic [IDW-1:0] cur_r;
  logic [AW-1:0]  cur_entry_r;

  // pending result
  rrtm_pkg::op_t             res_op_r;
  rrtm_pkg::status_t         res_status_r;
  logic [IDW-1:0]            res_tid_r;
  logic                      res_switched_r;
  logic [CNTW-1:0]           res_reaped_r;

  // output register
  logic                          out_valid_r;
  logic [rrtm_pkg::STATUS_W-1:0] out_status_r;
  logic [TIDW-1:0]               out_tid_r;
  logic                          out_switched_r;
  logic [AW-1:0]                 out_resume_r;
  logic [CW-1:0]                 out_run_r;
  logic [CW-1:0]                 out_reaped_r;

  // memories
  logic [IDW-1:0] fifo_mem [THREAD_SLOTS];
  logic [AW-1:0]  entry_mem [THREAD_SLOTS];
  logic [IDW-1:0] fifo_rdata_r;
  logic [AW-1:0]  entry_rdata_r;

  logic           in_fire;
  logic           out_fire;
  logic           out_load;
  rrtm_pkg::op_t  in_op;
  logic           found;
  logic [IDW-1:0] free_idx;
  logic           cur_alive;
  logic           fifo_we;
  logic [IDW-1:0] fifo_wdata;
  logic           entry_we;
  logic [IDW-1:0] pop_id;
  logic [IDW-1:0] head_inc;
  logic [IDW-1:0] tail_inc;
  logic [IDW-1:0] done_tid;
  logic [AW-1:0]  done_resume;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && (state_r == S_IDLE);
  assign out_fire    = out_valid_r && out_ch.ready;
  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign in_op       = rrtm_pkg::op_t'(in_ch.op);

  assign head_inc = (head_r == LAST_ID) ? '0 : head_r + 1'b1;
  assign tail_inc = (tail_r == LAST_ID) ? '0 : tail_r + 1'b1;

  // a live current thread is one that has not exited
  assign cur_alive = cur_valid_r && !dead_r[cur_r];

  // popped id: forwarded from the requeued current thread when the queue was empty
  assign pop_id = fwd_r ? cur_r : fifo_rdata_r;

  // lowest free slot
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
      if (free_r[i]) begin
        found    = 1'b1;
        free_idx = IDW'(i);
      end
    end
  end

  // memory write controls, used only on an accepted command
  always_comb begin
    fifo_we    = 1'b0;
    fifo_wdata = cur_r;
    entry_we   = 1'b0;
    if (in_fire) begin
      case (in_op)
        rrtm_pkg::OP_CREATE: begin
          fifo_we    = found;
          fifo_wdata = free_idx;
          entry_we   = found;
        end
        rrtm_pkg::OP_YIELD: begin
          fifo_we = cur_alive;
        end
        default: begin
          fifo_we = 1'b0;
        end
      endcase
    end
  end

  // run queue memory, read at the head every cycle
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      fifo_mem[tail_r] <= fifo_wdata;
    end
    fifo_rdata_r <= fifo_mem[head_r];
  end

  // entry address table, read at the popped id
  always_ff @(posedge clk) begin
    if (entry_we) begin
      entry_mem[free_idx] <= in_ch.entry_addr;
    end
    entry_rdata_r <= entry_mem[pop_id];
  end

  // result fields that follow the state after the step
  always_comb begin
    done_tid    = '0;
    done_resume = '0;
    if (cur_valid_r) begin
      done_tid    = cur_r;
      done_resume = cur_entry_r;
    end
    if (res_op_r == rrtm_pkg::OP_CREATE) begin
      done_tid = res_tid_r;
    end
  end

  // sequencer, slot state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_r      <= '1;
      dead_r      <= '0;
      dead_cnt_r  <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      fwd_r       <= 1'b0;
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // a beat leaving with no new one behind it empties the output register
      if (out_fire && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            res_op_r       <= in_op;
            res_switched_r <= 1'b0;
            case (in_op)
              rrtm_pkg::OP_CREATE: begin
                res_reaped_r <= '0;
                state_r      <= S_DONE;
                if (found) begin
                  free_r[free_idx] <= 1'b0;
                  tail_r           <= tail_inc;
                  count_r          <= count_r + 1'b1;
                  res_tid_r        <= free_idx;
                  res_status_r     <= rrtm_pkg::STAT_OK;
                end else begin
                  res_tid_r    <= '0;
                  res_status_r <= rrtm_pkg::STAT_NO_FREE;
                end
              end
              rrtm_pkg::OP_YIELD: begin
                res_tid_r    <= '0;
                res_reaped_r <= '0;
                if (cur_alive) begin
                  tail_r <= tail_inc;
                end
                if (count_r == '0 && !cur_alive) begin
                  res_status_r <= rrtm_pkg::STAT_NO_RUN;
                  state_r      <= S_DONE;
                end else begin
                  // requeue and pop in the same step: net count change is push - 1
                  res_status_r <= rrtm_pkg::STAT_OK;
                  fwd_r        <= (count_r == '0);
                  head_r       <= head_inc;
                  count_r      <= cur_alive ? count_r : count_r - 1'b1;
                  state_r      <= S_FIFO;
                end
              end
              rrtm_pkg::OP_EXIT: begin
                res_tid_r    <= '0;
                res_reaped_r <= '0;
                state_r      <= S_DONE;
                if (cur_alive) begin
                  dead_r[cur_r] <= 1'b1;
                  dead_cnt_r    <= dead_cnt_r + 1'b1;
                  res_status_r  <= rrtm_pkg::STAT_OK;
                end else begin
                  res_status_r <= rrtm_pkg::STAT_NO_RUN;
                end
              end
              default: begin
                // reap: every dead slot goes back to the free set
                res_tid_r    <= '0;
                res_status_r <= rrtm_pkg::STAT_OK;
                state_r      <= S_DONE;
                free_r       <= free_r | dead_r;
                dead_r       <= '0;
                dead_cnt_r   <= '0;
                res_reaped_r <= dead_cnt_r;
                if (cur_valid_r && dead_r[cur_r]) begin
                  cur_valid_r <= 1'b0;
                end
              end
            endcase
          end
        end
        S_FIFO: begin
          res_switched_r <= !cur_valid_r || (cur_r != pop_id);
          cur_r          <= pop_id;
          cur_valid_r    <= 1'b1;
          state_r        <= S_ENTRY;
        end
        S_ENTRY: begin
          cur_entry_r <= entry_rdata_r;
          state_r     <= S_DONE;
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= res_status_r;
            out_tid_r      <= TIDW'({{TIDW{1'b0}}, done_tid});
            out_switched_r <= res_switched_r;
            out_resume_r   <= done_resume;
            out_run_r      <= CW'({{CW{1'b0}}, count_r});
            out_reaped_r   <= CW'({{CW{1'b0}}, res_reaped_r});
            state_r        <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.thread_id    = out_tid_r;
  assign out_ch.switched     = out_switched_r;
  assign out_ch.resume_addr  = out_resume_r;
  assign out_ch.run_count    = out_run_r;
  assign out_ch.reaped_count = out_reaped_r;

endmodule
